/* rtl/sfr_pkg.sv */
// shared types, constants and helpers for the string find-and-replace core
package sfr_pkg;

  localparam int MAX_BYTES = 8;
  localparam int BYTE_IDX_W = 3;
  localparam int CNT_W = 4;
  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPLACEMENT_MAX_DEF = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] REG_PATTERN = 3'd0;
  localparam logic [2:0] REG_PATTERN_LENGTH = 3'd1;
  localparam logic [2:0] REG_REPLACEMENT = 3'd2;
  localparam logic [2:0] REG_REPLACEMENT_LENGTH = 3'd3;
  localparam logic [2:0] REG_IGNORE_CASE = 3'd4;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0] win_cnt;
    logic [CNT_W-1:0] rep_cnt;
    logic fin;
  } entry_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    logic [7:0] r;
    r = c;
    if (ic && c >= 8'h41 && c <= 8'h5a) r = c + 8'h20;
    return r;
  endfunction

endpackage

/* rtl/sfr_front.sv */
// front end: pending window, pattern compare and per-item command build
module sfr_front #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACEMENT_MAX = sfr_pkg::REPLACEMENT_MAX_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic [7:0] text_byte,
  input  logic final_byte,
  input  logic [63:0] pattern,
  input  logic [3:0] pattern_length,
  input  logic [3:0] replacement_length,
  input  logic ignore_case,
  output sfr_pkg::entry_t entry,
  output logic entry_valid
);
  import sfr_pkg::*;

  localparam int WIN = PATTERN_MAX < MAX_BYTES ? PATTERN_MAX : MAX_BYTES;
  localparam int RCAP = REPLACEMENT_MAX < MAX_BYTES ? REPLACEMENT_MAX : MAX_BYTES;

  logic [7:0] window [WIN];
  logic [7:0] window_next [WIN];
  logic [CNT_W-1:0] count, count_next;
  logic [7:0] seq [WIN];
  logic [7:0] sh [WIN];
  logic [CNT_W-1:0] plen, rlen, pre, fill;
  logic full_win, match;

  always_comb begin
    plen = pattern_length;
    if (plen == '0) plen = CNT_W'(1);
    if (plen > CNT_W'(WIN)) plen = CNT_W'(WIN);
    rlen = replacement_length;
    if (rlen > CNT_W'(RCAP)) rlen = CNT_W'(RCAP);

    for (int i = 0; i < WIN; i++) begin
      seq[i] = (CNT_W'(i) == count) ? text_byte : window[i];
    end
    pre = (count >= plen) ? count - plen + CNT_W'(1) : '0;
    for (int i = 0; i < WIN; i++) begin
      sh[i] = '0;
      for (int k = 0; k < WIN; k++) begin
        if (CNT_W'(k) == CNT_W'(i) + pre) sh[i] = seq[k];
      end
    end
    fill = count + CNT_W'(1) - pre;
    full_win = (fill == plen);
    match = full_win;
    for (int i = 0; i < WIN; i++) begin
      if (CNT_W'(i) < plen &&
          fold(sh[i], ignore_case) != fold(pattern[8*i +: 8], ignore_case)) begin
        match = 1'b0;
      end
    end

    entry = '0;
    for (int i = 0; i < WIN; i++) begin
      entry.bytes[i] = seq[i];
    end
    entry.fin = final_byte;
    window_next = sh;
    if (match) begin
      entry.win_cnt = pre;
      entry.rep_cnt = rlen;
      count_next = '0;
    end else if (full_win) begin
      entry.win_cnt = pre + CNT_W'(1);
      count_next = plen - CNT_W'(1);
      for (int i = 0; i < WIN - 1; i++) begin
        window_next[i] = sh[i+1];
      end
    end else begin
      entry.win_cnt = '0;
      count_next = fill;
    end
    if (final_byte) begin
      if (!match) entry.win_cnt = count + CNT_W'(1);
      count_next = '0;
    end
    entry_valid = accept && (entry.win_cnt != '0 || entry.rep_cnt != '0 || final_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

/* rtl/sfr_queue.sv */
// short command queue between front and back ends
module sfr_queue #(
  parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  sfr_pkg::entry_t din,
  output logic full,
  input  logic pop,
  output sfr_pkg::entry_t dout,
  output logic empty
);
  import sfr_pkg::*;

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;

  entry_t store [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0] count;
  logic do_push, do_pop;

  assign full = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign dout = store[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop) count <= count + (PW+1)'(1);
      else if (do_pop && !do_push) count <= count - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= din;
    end
  end

endmodule

/* rtl/sfr_back.sv */
// back end: expands one command into its result bytes
module sfr_back (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  sfr_pkg::entry_t q_dout,
  output logic q_pop,
  input  logic [63:0] replacement,
  output logic empty,
  input  logic pop,
  output logic [7:0] out_byte,
  output logic byte_present,
  output logic run_last,
  output logic string_end
);
  import sfr_pkg::*;

  entry_t cur;
  logic busy;
  logic [CNT_W:0] pos, total, rep_pos;
  logic last, take, load;

  assign total = {1'b0, cur.win_cnt} + {1'b0, cur.rep_cnt};
  assign last = (total == '0) || (pos == total - (CNT_W+1)'(1));
  assign rep_pos = pos - {1'b0, cur.win_cnt};
  assign take = pop && busy;
  assign load = (!busy || (take && last)) && !q_empty;
  assign q_pop = load;
  assign empty = !busy;

  always_comb begin
    // empty end marker carries a zero byte
    if (total == '0) out_byte = '0;
    else if (pos < {1'b0, cur.win_cnt}) out_byte = cur.bytes[pos[BYTE_IDX_W-1:0]];
    else out_byte = replacement[8*rep_pos[BYTE_IDX_W-1:0] +: 8];
    byte_present = (total != '0);
    run_last = last;
    string_end = cur.fin && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos <= '0;
    end else if (load) begin
      busy <= 1'b1;
      pos <= '0;
    end else if (take) begin
      if (last) busy <= 1'b0;
      pos <= pos + (CNT_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_dout;
    end
  end

endmodule

/* rtl/string_find_and_replace_core.sv */
// top level of the streaming string find-and-replace core
// usage:
//   text enters one byte per transfer on push/full with final_byte on the
//   last byte of a string; results leave on empty/pop, oldest first, one
//   byte (or an empty end marker) per transfer with run_last and string_end
//   flags. on cfg_valid/cfg_ready (always ready) the user must write the
//   configuration only while the core is idle, which the core does not
//   enforce; indexes beyond the register list are dropped.
// throughput: one input byte per cycle while each byte yields at most one
//   result and pop is held high; an item with several results needs one pop
//   per result, and the two-entry command queue fills and raises full.
// path: each result is registered in the command queue, then in cur.
// reset: clears the pending window count, the queue and the result stage,
//   and returns the registers to pattern length one with no replacement.
// a stalled pop holds the current result; the front keeps taking bytes until
//   the command queue is full.
module string_find_and_replace_core #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACEMENT_MAX = sfr_pkg::REPLACEMENT_MAX_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [7:0] text_byte,
  input  logic final_byte,
  output logic empty,
  input  logic pop,
  output logic [7:0] out_byte,
  output logic byte_present,
  output logic run_last,
  output logic string_end,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data
);
  import sfr_pkg::*;

  logic [63:0] pattern, replacement;
  logic [3:0] pattern_length, replacement_length;
  logic ignore_case;
  logic accept, entry_valid, q_empty, q_pop;
  entry_t entry, q_dout;

  assign cfg_ready = 1'b1;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
      pattern_length <= 4'd1;
      replacement <= '0;
      replacement_length <= '0;
      ignore_case <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN: pattern <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[3:0];
        REG_REPLACEMENT: replacement <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
        REG_IGNORE_CASE: ignore_case <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sfr_front #(
    .PATTERN_MAX(PATTERN_MAX),
    .REPLACEMENT_MAX(REPLACEMENT_MAX)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .text_byte(text_byte),
    .final_byte(final_byte),
    .pattern(pattern),
    .pattern_length(pattern_length),
    .replacement_length(replacement_length),
    .ignore_case(ignore_case),
    .entry(entry),
    .entry_valid(entry_valid)
  );

  sfr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(entry_valid),
    .din(entry),
    .full(full),
    .pop(q_pop),
    .dout(q_dout),
    .empty(q_empty)
  );

  sfr_back u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_dout(q_dout),
    .q_pop(q_pop),
    .replacement(replacement),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .byte_present(byte_present),
    .run_last(run_last),
    .string_end(string_end)
  );

endmodule

/* test/string_find_and_replace_core_tb.sv */
// string find-and-replace core testbench: directed and random text vs. a self-checking predictor
`timescale 1ns / 100ps

module string_find_and_replace_core_tb;
  import sfr_pkg::*;

  localparam logic [2:0] REG_NONE_LO = 3'd5;
  localparam logic [2:0] REG_NONE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] data;
    logic fin;
  } text_in_t;

  typedef struct packed {
    logic [7:0] data;
    logic present;
    logic run_last;
    logic string_end;
  } text_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [7:0] text_byte = 8'h00;
  logic final_byte = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = REG_PATTERN;
  logic [63:0] cfg_data = 64'h0;
  logic full, empty, byte_present, run_last, string_end, cfg_ready;
  logic [7:0] out_byte;

  // predictor copy of registers and window
  logic [63:0] pat_reg = 64'h0;
  logic [3:0] pat_len_reg = 4'd1;
  logic [63:0] rep_reg = 64'h0;
  logic [3:0] rep_len_reg = 4'd0;
  logic nocase_reg = 1'b0;
  logic [7:0] win_buf [MAX_BYTES];
  int win_fill = 0;

  text_in_t text_q [$];
  text_out_t expected_out [$];
  text_in_t next_in;
  text_out_t got, want;

  int n_queued = 0;
  int n_taken = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_cnt = 0;
  bit in_taken = 1'b0;

  string_find_and_replace_core dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .text_byte(text_byte),
    .final_byte(final_byte),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .byte_present(byte_present),
    .run_last(run_last),
    .string_end(string_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_plen();
    if (pat_len_reg == 0) return 1;
    if (pat_len_reg > MAX_BYTES) return MAX_BYTES;
    return int'(pat_len_reg);
  endfunction

  function automatic logic [7:0] lower_if_nocase(logic [7:0] c);
    if (nocase_reg && c >= 8'h41 && c <= 8'h5a) return c + 8'h20;
    return c;
  endfunction

  function automatic text_out_t shift_oldest();
    text_out_t r;
    int i;
    r = '{data: win_buf[0], present: 1'b1, run_last: 1'b0, string_end: 1'b0};
    for (i = 1; i < win_fill; i++) win_buf[i-1] = win_buf[i];
    win_fill--;
    return r;
  endfunction

  function automatic void replace_step(logic [7:0] b, logic fin);
    text_out_t outs [$];
    int plen, rlen, i;
    bit hit;
    plen = eff_plen();
    rlen = (rep_len_reg > MAX_BYTES) ? MAX_BYTES : int'(rep_len_reg);
    // a lowered length leaves too many bytes pending
    while (win_fill >= plen) outs.push_back(shift_oldest());
    if (win_fill < MAX_BYTES) begin
      win_buf[win_fill] = b;
      win_fill++;
    end
    if (win_fill == plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++) begin
        if (lower_if_nocase(win_buf[i]) != lower_if_nocase(pat_reg[i*8 +: 8])) hit = 1'b0;
      end
      if (hit) begin
        for (i = 0; i < rlen; i++) begin
          outs.push_back('{data: rep_reg[i*8 +: 8], present: 1'b1, run_last: 1'b0,
                           string_end: 1'b0});
        end
        win_fill = 0;
      end else begin
        outs.push_back(shift_oldest());
      end
    end
    if (fin) begin
      while (win_fill > 0) outs.push_back(shift_oldest());
      if (outs.size() == 0) begin
        outs.push_back('{data: 8'h00, present: 1'b0, run_last: 1'b0, string_end: 1'b0});
      end
    end
    if (outs.size() > 0) begin
      outs[outs.size()-1].run_last = 1'b1;
      if (fin) outs[outs.size()-1].string_end = 1'b1;
    end
    for (i = 0; i < outs.size(); i++) expected_out.push_back(outs[i]);
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      REG_PATTERN: pat_reg = val;
      REG_PATTERN_LENGTH: pat_len_reg = val[3:0];
      REG_REPLACEMENT: rep_reg = val;
      REG_REPLACEMENT_LENGTH: rep_len_reg = val[3:0];
      REG_IGNORE_CASE: nocase_reg = val[0];
      default: ;
    endcase
  endfunction

  function automatic void note_fail(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endfunction

  // monitor: result check, input transfers and register writes
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        got = '{data: out_byte, present: byte_present, run_last: run_last,
                string_end: string_end};
        if (expected_out.size() == 0) begin
          note_fail($sformatf("unexpected result: byte %02h present %0b last %0b end %0b",
                              got.data, got.present, got.run_last, got.string_end));
        end else begin
          want = expected_out.pop_front();
          if (got.data !== want.data || got.present !== want.present ||
              got.run_last !== want.run_last || got.string_end !== want.string_end) begin
            note_fail($sformatf({"mismatch: expected byte %02h present %0b last %0b end %0b,",
                                 " got byte %02h present %0b last %0b end %0b"},
                                want.data, want.present, want.run_last, want.string_end,
                                got.data, got.present, got.run_last, got.string_end));
          end
        end
      end
      in_taken = push && !full;
      if (in_taken) begin
        replace_step(text_byte, final_byte);
        n_taken++;
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst && (!push || in_taken)) begin
      if (text_q.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
        next_in = text_q.pop_front();
        text_byte <= next_in.data;
        final_byte <= next_in.fin;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= (hold_cnt == 0) && ($urandom_range(0, 99) >= rx_idle);
  end

  // long receiver hold-off
  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_ack != hold_req) begin
      hold_cnt <= HOLD_CYCLES;
      hold_ack <= hold_req;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_item(logic [7:0] b, logic fin);
    text_q.push_back('{data: b, fin: fin});
    n_queued++;
  endtask

  task automatic add_text(string s, bit close);
    int i;
    for (i = 0; i < s.len(); i++) add_item(s[i], close && i == s.len() - 1);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (n_taken != n_queued || expected_out.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'h61 + 8'($urandom_range(0, 3));
    if (r < 8) return 8'h41 + 8'($urandom_range(0, 3));
    if (r == 8) return 8'($urandom_range(0, 255));
    // characters at and next to the letter ranges
    case ($urandom_range(0, 5))
      0: return 8'h40;
      1: return 8'h5b;
      2: return 8'h60;
      3: return 8'h7b;
      4: return 8'h5a;
      default: return 8'h7a;
    endcase
  endfunction

  task automatic random_setup();
    logic [63:0] pat, junk;
    logic [3:0] plen, rlen;
    logic nc;
    int r, k;
    for (k = 0; k < MAX_BYTES; k++) pat[k*8 +: 8] = pick_char();
    r = $urandom_range(0, 9);
    if (r < 6) plen = 4'($urandom_range(1, 4));
    else if (r < 9) plen = 4'($urandom_range(5, 8));
    else plen = 4'($urandom_range(0, 15));
    rlen = 4'($urandom_range(0, 15));
    nc = 1'($urandom_range(0, 1));
    junk = {$urandom, $urandom};
    write_reg(REG_PATTERN, pat);
    write_reg(REG_PATTERN_LENGTH, {junk[63:4], plen});
    write_reg(REG_REPLACEMENT, {$urandom, $urandom});
    write_reg(REG_REPLACEMENT_LENGTH, {junk[63:4], rlen});
    write_reg(REG_IGNORE_CASE, {junk[63:1], nc});
    if ($urandom_range(0, 2) == 0) begin
      write_reg(3'($urandom_range(REG_NONE_LO, REG_NONE_HI)), {$urandom, $urandom});
    end
  endtask

  task automatic add_random_string(bit close);
    logic [7:0] s [$];
    logic [7:0] c;
    int len, plen, k;
    bit noise;
    plen = eff_plen();
    len = $urandom_range(1, 14);
    noise = ($urandom_range(0, 9) == 0);
    while (s.size() < len) begin
      if (!noise && $urandom_range(0, 1) == 1) begin
        // pattern copy, with case flips and the odd corrupted byte
        for (k = 0; k < plen; k++) begin
          c = pat_reg[k*8 +: 8];
          if ($urandom_range(0, 3) == 0 &&
              ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a))) c = c ^ 8'h20;
          if ($urandom_range(0, 11) == 0) c = 8'($urandom_range(0, 255));
          s.push_back(c);
        end
      end else begin
        if (noise) c = 8'($urandom_range(0, 255));
        else c = pick_char();
        s.push_back(c);
      end
    end
    for (k = 0; k < s.size(); k++) add_item(s[k], close && k == s.size() - 1);
  endtask

  task automatic random_block(int count, int tx, int rx, bit stall);
    int start;
    wait_idle();
    random_setup();
    @(posedge clk);
    tx_idle = tx;
    rx_idle = rx;
    if (stall) hold_req++;
    start = n_queued;
    while (n_queued - start < count) add_random_string($urandom_range(0, 9) != 0);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle = 14;
    rx_idle = 83;
    // reset registers: zero byte pattern, empty replacement
    add_item(8'h00, 1'b0);
    add_item(8'h41, 1'b1);
    add_item(8'h00, 1'b1);

    wait_idle();
    write_reg(REG_PATTERN, 64'h0000_0000_0063_6261);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    write_reg(REG_REPLACEMENT, 64'h5958);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd2);
    write_reg(REG_IGNORE_CASE, 64'd0);
    @(posedge clk);
    add_text("zabca", 1'b1);

    // lengths above the cap saturate, unused index dropped
    wait_idle();
    write_reg(REG_PATTERN, '1);
    write_reg(REG_PATTERN_LENGTH, 64'hf);
    write_reg(REG_REPLACEMENT, {$urandom, $urandom});
    write_reg(REG_REPLACEMENT_LENGTH, '1);
    write_reg(REG_NONE_HI, 64'h0);
    @(posedge clk);
    repeat (MAX_BYTES) add_item(8'hff, 1'b0);
    add_item(8'h80, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'h7f, 1'b0);
    add_item(8'h55, 1'b0);
    add_item(8'haa, 1'b0);
    add_item(8'h01, 1'b0);
    add_item(8'hfe, 1'b0);

    // zero length with seven bytes pending
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 64'h0);
    write_reg(REG_PATTERN, 64'h71);
    @(posedge clk);
    add_item(8'h71, 1'b1);

    wait_idle();
    write_reg(REG_IGNORE_CASE, 64'd1);
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    write_reg(REG_PATTERN, 64'h5b61);
    write_reg(REG_REPLACEMENT, 64'h23);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd1);
    @(posedge clk);
    add_text("A[A{", 1'b1);

    random_block(22, 14, 83, 1'b1);
    random_block(22, 14, 83, 1'b0);
    random_block(22, 14, 83, 1'b0);
    random_block(22, 83, 14, 1'b0);
    random_block(22, 83, 14, 1'b0);
    random_block(22, 83, 14, 1'b0);
    random_block(22, 0, 0, 1'b1);
    random_block(22, 0, 0, 1'b0);
    random_block(22, 0, 0, 1'b0);

    wait_idle();
    if (err_cnt == 0 && expected_out.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
